@@ src/mi25519_pkg.sv @@
// Package for the p25519 divstep inverter: widths, prime, sequencer states.
// No dependencies.
`default_nettype none
package mi25519_pkg;
    localparam int unsigned W = 256;
    localparam int unsigned FW = 320;
    localparam int unsigned DIVSTEPS = 600;
    localparam logic [W-1:0] PRIME = {1'b0, {250{1'b1}}, 5'b01101};

    typedef enum logic [2:0] {
        t_IDLE, t_RED, t_STEP, t_FIX, t_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctl;
endpackage
`default_nettype wire

@@ src/mi25519_step.sv @@
// One divstep on f, g, v, s per enabled cycle (shared step unit).
// Depends on mi25519_pkg.
`default_nettype none
module mi25519_step (
    input  wire logic                          i_clk,
    input  wire mi25519_pkg::t_ctl             i_ctl,
    input  wire logic [mi25519_pkg::W-1:0]     i_x,
    output logic [mi25519_pkg::FW-1:0]         o_f,
    output logic [mi25519_pkg::W-1:0]          o_v
);
    logic [mi25519_pkg::FW-1:0] r_f, r_g, n_f, n_g, gs;
    logic [mi25519_pkg::W-1:0]  r_v, r_s, n_v, n_s, sa, sh;
    logic [mi25519_pkg::W:0]    sum;
    logic [11:0]                r_d, n_d;
    logic                       swp, odd;

    always_comb begin
        odd = r_g[0];
        swp = odd && !r_d[11] && (r_d != 12'd0);
        n_f = r_f; n_v = r_v; gs = r_g; sa = r_s;
        if (swp) begin
            gs  = r_g - r_f;
            n_f = r_g;
            n_v = r_s;
            sa  = (r_s >= r_v) ? r_s - r_v : r_s - r_v + mi25519_pkg::PRIME;
            n_d = 12'd2 - r_d;
        end else begin
            if (odd) begin
                gs  = r_g + r_f;
                sum = {1'b0, r_s} + {1'b0, r_v};
                sa  = (sum >= {1'b0, mi25519_pkg::PRIME}) ?
                      sum[mi25519_pkg::W-1:0] - mi25519_pkg::PRIME : sum[mi25519_pkg::W-1:0];
            end
            n_d = r_d + 12'd2;
        end
        sum = '0;
        if (sa[0]) sum = {1'b0, sa} + {1'b0, mi25519_pkg::PRIME};
        else       sum = {1'b0, sa};
        sh  = sum[mi25519_pkg::W:1];
        n_s = sh;
        n_g = {gs[mi25519_pkg::FW-1], gs[mi25519_pkg::FW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_f <= {64'd0, mi25519_pkg::PRIME};
            r_g <= {64'd0, i_x};
            r_v <= '0;
            r_s <= {{(mi25519_pkg::W-1){1'b0}}, 1'b1};
            r_d <= 12'd1;
        end else if (i_ctl.step) begin
            r_f <= n_f; r_g <= n_g; r_v <= n_v; r_s <= n_s; r_d <= n_d;
        end
    end

    assign o_f = r_f;
    assign o_v = r_v;
endmodule
`default_nettype wire

@@ src/modular_inverse_p25519_divstep.sv @@
// Inverse modulo 2^255-19 by 600 constant-time divsteps, one per cycle.
// Steps: reduce the input twice, run the divsteps, then fix the sign; a zero
// input skips the divsteps and gives 0. One item at a time: a new input is
// taken only once the previous result has left, as there is a single step unit.
// Reset (synchronous, active low) returns the sequencer to idle, no result.
`default_nettype none
module modular_inverse_p25519_divstep (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_x_limb0,
    input  wire logic [63:0] i_x_limb1,
    input  wire logic [63:0] i_x_limb2,
    input  wire logic [63:0] i_x_limb3,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_inv_limb0,
    output logic [63:0]      o_inv_limb1,
    output logic [63:0]      o_inv_limb2,
    output logic [62:0]      o_inv_limb3
);
    mi25519_pkg::t_state r_st, n_st;
    mi25519_pkg::t_ctl   ctl;
    logic [255:0] r_x, r_res, n_res;
    logic [255:0] xr2;
    logic [9:0]   r_cnt;
    logic [319:0] f;
    logic [255:0] v;
    logic         r_red;

    // Conditionally subtract p once from the held value.
    assign xr2 = (r_x >= mi25519_pkg::PRIME) ? r_x - mi25519_pkg::PRIME : r_x;

    // Hold state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= mi25519_pkg::t_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        ctl  = '0;
        n_res = '0;
        unique case (r_st)
            mi25519_pkg::t_IDLE: if (i_valid) n_st = mi25519_pkg::t_RED;
            mi25519_pkg::t_RED: begin
                // two conditional subtracts, one per cycle; the second one
                // feeds the zero check and the load directly
                if (r_red) begin
                    if (xr2 == '0) n_st = mi25519_pkg::t_OUT;
                    else begin
                        n_st = mi25519_pkg::t_STEP;
                        ctl.load = 1'b1;
                    end
                end
            end
            mi25519_pkg::t_STEP: begin
                ctl.step = 1'b1;
                if (r_cnt == 10'(mi25519_pkg::DIVSTEPS - 1)) n_st = mi25519_pkg::t_FIX;
            end
            mi25519_pkg::t_FIX: n_st = mi25519_pkg::t_OUT;
            mi25519_pkg::t_OUT: if (!i_stall) n_st = mi25519_pkg::t_IDLE;
            default: n_st = mi25519_pkg::t_IDLE;
        endcase
        // negate v when final f is -1
        if (f[319] && v != '0) n_res = mi25519_pkg::PRIME - v;
        else                   n_res = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_st == mi25519_pkg::t_IDLE && i_valid) begin
                r_x   <= {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0};
                r_red <= 1'b0;
                r_res <= '0;
            end
            if (r_st == mi25519_pkg::t_RED) begin
                r_x   <= xr2;
                r_red <= 1'b1;
            end
            if (ctl.load) r_cnt <= '0;
            else if (ctl.step) r_cnt <= r_cnt + 10'd1;
            if (r_st == mi25519_pkg::t_FIX) r_res <= n_res;
        end
    end

    mi25519_step u_step (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_x   (xr2),
        .o_f   (f),
        .o_v   (v)
    );

    assign o_stall     = (r_st != mi25519_pkg::t_IDLE);
    assign o_valid     = (r_st == mi25519_pkg::t_OUT);
    assign o_inv_limb0 = r_res[63:0];
    assign o_inv_limb1 = r_res[127:64];
    assign o_inv_limb2 = r_res[191:128];
    assign o_inv_limb3 = r_res[254:192];

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_res))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == mi25519_pkg::t_STEP |-> o_stall && !o_valid)
        else $error("ready while stepping");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.step |-> r_cnt < 10'(mi25519_pkg::DIVSTEPS))
        else $error("step count overrun");
endmodule
`default_nettype wire

@@ tb/tb_modular_inverse_p25519_divstep.sv @@
// Testbench for modular_inverse_p25519_divstep: stepwise divstep predictor,
// random-gap driver and stalling receiver. Depends on mi25519_pkg and the RTL.
`default_nettype none
module tb_modular_inverse_p25519_divstep;

    typedef struct {
        logic [255:0] x;
        bit           drain_first;   // wait for all results before offering
    } t_x_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [63:0] i_x_limb0 = '0, i_x_limb1 = '0, i_x_limb2 = '0, i_x_limb3 = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [63:0] o_inv_limb0, o_inv_limb1, o_inv_limb2;
    logic [62:0] o_inv_limb3;

    t_x_beat      pending_x[$];
    logic [254:0] inverse_q[$];
    int  n_mismatch = 0;
    int  n_in = 0, n_out = 0, n_zero = 0;
    bit  in_taken = 1'b0;
    bit  calm = 1'b0;          // no idling on either side while set
    bit  hold_done = 1'b0;
    int  tx_gap = 0, rx_gap = 0, rx_hold = 0;

    modular_inverse_p25519_divstep i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stepwise form: halve s modulo p at every step, fix the sign of v from f last.
    function automatic logic [254:0] inverse_mod_p(logic [255:0] x);
        logic [255:0] xr;
        logic signed [mi25519_pkg::FW-1:0] f, g, tf;
        logic [256:0] v, s, t;
        int delta;
        xr = x;
        if (xr >= mi25519_pkg::PRIME) xr = xr - mi25519_pkg::PRIME;
        if (xr >= mi25519_pkg::PRIME) xr = xr - mi25519_pkg::PRIME;
        if (xr == 0) return '0;
        f = mi25519_pkg::PRIME;
        g = xr;
        v = 0;
        s = 1;
        delta = 1;
        for (int k = 0; k < mi25519_pkg::DIVSTEPS; k++) begin
            if (delta > 0 && g[0]) begin
                tf = g;
                g = g - f;
                f = tf;
                t = (s >= v) ? s - v : s + mi25519_pkg::PRIME - v;
                v = s;
                s = t;
                delta = 2 - delta;
            end else begin
                if (g[0]) begin
                    g = g + f;
                    s = s + v;
                    if (s >= mi25519_pkg::PRIME) s = s - mi25519_pkg::PRIME;
                end
                delta = delta + 2;
            end
            g = g >>> 1;
            s = s[0] ? (s + mi25519_pkg::PRIME) >> 1 : s >> 1;
        end
        if (f < 0 && v != 0) v = mi25519_pkg::PRIME - v;
        return v[254:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(9) == 0) return $urandom_range(60, 10);
        return $urandom_range(3);
    endfunction

    function automatic logic [255:0] rand_x();
        logic [255:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(7))
            0: r = mi25519_pkg::PRIME + r[7:0];         // just above p
            1: r = mi25519_pkg::PRIME - r[7:0];         // just below p
            2: r = r[31:0];                             // small values
            3: r = {1'b1, r[254:0]};                    // above 2p possible
            default: ;
        endcase
        return r;
    endfunction

    // Driver: advance to the next beat at the falling edge, hold while stalled.
    always @(negedge i_clk) begin
        automatic logic nv = 1'b0;
        automatic t_x_beat b;
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                nv = 1'b1;                              // hold the stalled beat
            end else if (tx_gap > 0 && !calm) begin
                tx_gap--;
            end else if (pending_x.size() > 0 &&
                         !(pending_x[0].drain_first && inverse_q.size() != 0)) begin
                b = pending_x.pop_front();
                {i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0} <= b.x;
                nv = 1'b1;
                tx_gap = idle_len();
            end
            i_valid <= nv;
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up.
    always @(negedge i_clk) begin
        automatic logic ns = 1'b0;
        if (i_rst_n) begin
            if (!hold_done && n_out == 200) begin
                hold_done = 1'b1;
                rx_hold = 3000;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                ns = 1'b1;
            end else if (rx_gap > 0 && !calm) begin
                rx_gap--;
                ns = 1'b1;
            end else if ($urandom_range(3) == 0) begin
                rx_gap = idle_len();
            end
            i_stall <= ns;
        end
    end

    // Accept input beats: predict the inverse for each one.
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            inverse_q.push_back(inverse_mod_p({i_x_limb3, i_x_limb2, i_x_limb1, i_x_limb0}));
            n_in++;
        end
    end

    // Check result beats against the oldest prediction.
    always @(posedge i_clk) begin
        logic [254:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (inverse_q.size() == 0) begin
                $error("result beat with no input outstanding");
                n_mismatch++;
            end else begin
                want = inverse_q.pop_front();
                if (want == 0) n_zero++;
                if (o_inv_limb0 !== want[63:0]) begin
                    $error("inv_limb0: expected %h, got %h", want[63:0], o_inv_limb0);
                    n_mismatch++;
                end
                if (o_inv_limb1 !== want[127:64]) begin
                    $error("inv_limb1: expected %h, got %h", want[127:64], o_inv_limb1);
                    n_mismatch++;
                end
                if (o_inv_limb2 !== want[191:128]) begin
                    $error("inv_limb2: expected %h, got %h", want[191:128], o_inv_limb2);
                    n_mismatch++;
                end
                if (o_inv_limb3 !== want[254:192]) begin
                    $error("inv_limb3: expected %h, got %h", want[254:192], o_inv_limb3);
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        logic [255:0] directed[$];
        t_x_beat b;
        directed = '{256'd0, 256'd1, 256'd2, 256'd3,
                     mi25519_pkg::PRIME - 1, mi25519_pkg::PRIME, mi25519_pkg::PRIME + 1,
                     mi25519_pkg::PRIME << 1, (mi25519_pkg::PRIME << 1) + 1,
                     {256{1'b1}}, {1'b0, {255{1'b1}}},
                     256'd1 << 255, 256'd19, 256'd20, 256'd1 << 254,
                     mi25519_pkg::PRIME >> 1,
                     {4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}}};
        foreach (directed[i]) begin
            b.x = directed[i];
            b.drain_first = 1'b0;
            pending_x.push_back(b);
        end
        for (int i = 0; i < 450; i++) begin
            b.x = rand_x();
            b.drain_first = (i == 300);
            pending_x.push_back(b);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run a stretch with no idling once the first hundred results are in.
        wait (n_out >= 100);
        calm = 1'b1;
        wait (n_out >= 140);
        calm = 1'b0;

        wait (pending_x.size() == 0 && !i_valid);
        wait (inverse_q.size() == 0);
        repeat (700) @(posedge i_clk);
        $display("Inverted %0d values (%0d congruent to zero), including bounds around p and 2p.",
                 n_in, n_zero);
        $display("Checked %0d results under random gaps, stalls and a long receiver hold.",
                 n_out);
        if (n_mismatch == 0 && inverse_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(12 * 3_000_000);
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
